### rtl/hpt_pkg.sv
package hpt_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_NUM_DETECTORS = 8;
	localparam int DEF_NUM_PATTERNS  = 8;
	localparam int DEF_COUNT_WIDTH   = 4;

	// Fixed field widths of the stream items
	localparam int FUNC_W   = 2;
	localparam int DET_W    = 3;
	localparam int PAT_W    = 3;
	localparam int MODE_W   = 2;
	localparam int REQ_W    = 4;
	localparam int CFG_W    = 4;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_HIT   = 2'd1,
		FUNC_WRITE = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	// Row modes; code 3 is stored but never matches a mode below
	localparam logic [MODE_W-1:0] MODE_VETOABLE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FORCED   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_VETO     = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DETECTORS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERNS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IGNORE    = 2'd2;

	typedef struct packed {
		func_t             func;
		logic [DET_W-1:0]  detector;
		logic [PAT_W-1:0]  pattern;
		logic [MODE_W-1:0] mode;
		logic [REQ_W-1:0]  required_count;
		logic              more_allowed;
	} item_t;

	typedef struct packed {
		logic [CFG_W-1:0] det_use;
		logic [CFG_W-1:0] pat_use;
		logic             ignore_vetoes;
	} cfg_t;

	typedef struct packed {
		logic triggered;
		logic vetoed;
		logic forced;
		logic saturated;
	} decision_t;

endpackage

### rtl/hit_pattern_trigger_veto.sv
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid / s_tready  tuser func, tdata detector..more_allowed
// m_*       out  m_tvalid / m_tready  tdata accepted..saturated
// cfg_*     in   cfg_we (no wait)     cfg_index, cfg_data
//
// An item is captured in the input register, then the counter/table update
// and all pattern compares run in one pass into the result register, which
// also latches the new state. One item per cycle while m_tready is high; the
// rate is set by that single compare pass. Reset clears the counters, config
// and valids; pattern cells hold garbage until written. A waiting result stalls
// only once the input register is full.
module hit_pattern_trigger_veto import hpt_pkg::*; #(
	parameter int NUM_DETECTORS = DEF_NUM_DETECTORS,
	parameter int NUM_PATTERNS  = DEF_NUM_PATTERNS,
	parameter int COUNT_WIDTH   = DEF_COUNT_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // detector[2:0] pattern[5:3] mode[7:6]
	                                        // required_count[11:8] more_allowed[12]
	input  logic [FUNC_W-1:0]    s_tuser,   // func[1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // accepted[0] triggered[1] vetoed[2]
	                                        // forced_trigger[3] saturated[4]
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	item_t     item_s1;
	logic      valid_s1;
	logic      advance;
	cfg_t      cfg_q;
	logic      accepted;
	decision_t dec;
	logic [4:0] result_q;
	logic       out_valid_q;

	logic [COUNT_WIDTH-1:0] cnt_next      [NUM_DETECTORS];
	logic [REQ_W-1:0]       cell_cnt_next [NUM_PATTERNS][NUM_DETECTORS];
	logic                   cell_min_next [NUM_PATTERNS][NUM_DETECTORS];
	logic [MODE_W-1:0]      mode_next     [NUM_PATTERNS];

	// The held item moves on whenever the result slot is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input payload register, no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.func           <= func_t'(s_tuser);
			item_s1.detector       <= s_tdata[2:0];
			item_s1.pattern        <= s_tdata[5:3];
			item_s1.mode           <= s_tdata[7:6];
			item_s1.required_count <= s_tdata[11:8];
			item_s1.more_allowed   <= s_tdata[12];
		end
	end

	// Config registers; writes must come only while idle, which the block itself does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.det_use       <= CFG_W'(8);
			cfg_q.pat_use       <= '0;
			cfg_q.ignore_vetoes <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DETECTORS: cfg_q.det_use       <= cfg_data;
				CFG_PATTERNS:  cfg_q.pat_use       <= cfg_data;
				CFG_IGNORE:    cfg_q.ignore_vetoes <= cfg_data[0];
				default: ;
			endcase
		end
	end

	hpt_counters #(
		.NUM_DETECTORS(NUM_DETECTORS),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_counters (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (advance),
		.item    (item_s1),
		.det_use (cfg_q.det_use),
		.cnt_next(cnt_next),
		.accepted(accepted)
	);

	hpt_table #(
		.NUM_DETECTORS(NUM_DETECTORS),
		.NUM_PATTERNS (NUM_PATTERNS)
	) u_table (
		.clk          (clk),
		.load         (advance),
		.item         (item_s1),
		.cell_cnt_next(cell_cnt_next),
		.cell_min_next(cell_min_next),
		.mode_next    (mode_next)
	);

	// Decision is taken on the state as it stands after this item
	hpt_eval #(
		.NUM_DETECTORS(NUM_DETECTORS),
		.NUM_PATTERNS (NUM_PATTERNS),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_eval (
		.cfg     (cfg_q),
		.cnt     (cnt_next),
		.cell_cnt(cell_cnt_next),
		.cell_min(cell_min_next),
		.mode    (mode_next),
		.dec     (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= {dec.saturated, dec.forced, dec.vetoed, dec.triggered, accepted};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, result_q};

endmodule

### rtl/hpt_counters.sv
module hpt_counters import hpt_pkg::*; #(
	parameter int NUM_DETECTORS = DEF_NUM_DETECTORS,
	parameter int COUNT_WIDTH   = DEF_COUNT_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  item_t                  item,
	input  logic [CFG_W-1:0]       det_use,
	output logic [COUNT_WIDTH-1:0] cnt_next [NUM_DETECTORS],
	output logic                   accepted
);

	logic [COUNT_WIDTH-1:0] cnt_q [NUM_DETECTORS];
	logic                   hit_ok;

	// det below detectors_in_use and below the table size
	assign hit_ok   = (item.func == FUNC_HIT) && (32'(item.detector) < 32'(det_use)) &&
	                  (32'(item.detector) < NUM_DETECTORS);
	assign accepted = hit_ok;

	always_comb begin
		for (int d = 0; d < NUM_DETECTORS; d++) begin
			cnt_next[d] = cnt_q[d];
			if (item.func == FUNC_CLEAR) begin
				cnt_next[d] = '0;
			end else if (hit_ok && (32'(item.detector) == d) && (cnt_q[d] != '1)) begin
				cnt_next[d] = cnt_q[d] + COUNT_WIDTH'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < NUM_DETECTORS; d++) cnt_q[d] <= '0;
		end else if (load) begin
			for (int d = 0; d < NUM_DETECTORS; d++) cnt_q[d] <= cnt_next[d];
		end
	end

endmodule

### rtl/hpt_table.sv
module hpt_table import hpt_pkg::*; #(
	parameter int NUM_DETECTORS = DEF_NUM_DETECTORS,
	parameter int NUM_PATTERNS  = DEF_NUM_PATTERNS
) (
	input  logic              clk,
	input  logic              load,
	input  item_t             item,
	output logic [REQ_W-1:0]  cell_cnt_next [NUM_PATTERNS][NUM_DETECTORS],
	output logic              cell_min_next [NUM_PATTERNS][NUM_DETECTORS],
	output logic [MODE_W-1:0] mode_next     [NUM_PATTERNS]
);

	logic [REQ_W-1:0]  cell_cnt_q [NUM_PATTERNS][NUM_DETECTORS];
	logic              cell_min_q [NUM_PATTERNS][NUM_DETECTORS];
	logic [MODE_W-1:0] mode_q     [NUM_PATTERNS];
	logic              wr;

	assign wr = (item.func == FUNC_WRITE);

	// Only the addressed cell and its row mode change; out-of-range writes hit nothing
	always_comb begin
		for (int p = 0; p < NUM_PATTERNS; p++) begin
			mode_next[p] = mode_q[p];
			if (wr && (32'(item.pattern) == p) && (32'(item.detector) < NUM_DETECTORS))
				mode_next[p] = item.mode;
			for (int d = 0; d < NUM_DETECTORS; d++) begin
				cell_cnt_next[p][d] = cell_cnt_q[p][d];
				cell_min_next[p][d] = cell_min_q[p][d];
				if (wr && (32'(item.pattern) == p) && (32'(item.detector) == d)) begin
					cell_cnt_next[p][d] = item.required_count;
					cell_min_next[p][d] = item.more_allowed;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int p = 0; p < NUM_PATTERNS; p++) begin
				mode_q[p] <= mode_next[p];
				for (int d = 0; d < NUM_DETECTORS; d++) begin
					cell_cnt_q[p][d] <= cell_cnt_next[p][d];
					cell_min_q[p][d] <= cell_min_next[p][d];
				end
			end
		end
	end

endmodule

### rtl/hpt_eval.sv
module hpt_eval import hpt_pkg::*; #(
	parameter int NUM_DETECTORS = DEF_NUM_DETECTORS,
	parameter int NUM_PATTERNS  = DEF_NUM_PATTERNS,
	parameter int COUNT_WIDTH   = DEF_COUNT_WIDTH
) (
	input  cfg_t                   cfg,
	input  logic [COUNT_WIDTH-1:0] cnt      [NUM_DETECTORS],
	input  logic [REQ_W-1:0]       cell_cnt [NUM_PATTERNS][NUM_DETECTORS],
	input  logic                   cell_min [NUM_PATTERNS][NUM_DETECTORS],
	input  logic [MODE_W-1:0]      mode     [NUM_PATTERNS],
	output decision_t              dec
);

	localparam int CMP_W = (COUNT_WIDTH > REQ_W) ? COUNT_WIDTH : REQ_W;

	logic [NUM_PATTERNS-1:0] row_hit;
	logic                    forced, vtrig, veto;

	always_comb begin
		logic [CMP_W-1:0] have, need;
		logic             ok;
		for (int p = 0; p < NUM_PATTERNS; p++) begin
			ok = 32'(cfg.pat_use) > p;
			for (int d = 0; d < NUM_DETECTORS; d++) begin
				have = CMP_W'(cnt[d]);
				need = CMP_W'(cell_cnt[p][d]);
				if (32'(cfg.det_use) > d) begin
					if (cell_min[p][d]) ok = ok && (have >= need);
					else                ok = ok && (have == need);
				end
			end
			row_hit[p] = ok;
		end
	end

	always_comb begin
		forced = 1'b0;
		vtrig  = 1'b0;
		veto   = 1'b0;
		dec.saturated = 1'b0;
		for (int p = 0; p < NUM_PATTERNS; p++) begin
			forced = forced || (row_hit[p] && (mode[p] == MODE_FORCED));
			vtrig  = vtrig  || (row_hit[p] && (mode[p] == MODE_VETOABLE));
			veto   = veto   || (row_hit[p] && (mode[p] == MODE_VETO));
		end
		veto = veto && !cfg.ignore_vetoes;
		for (int d = 0; d < NUM_DETECTORS; d++) begin
			dec.saturated = dec.saturated || (cnt[d] == '1);
		end
		dec.forced    = forced;
		dec.vetoed    = veto && !forced;
		dec.triggered = forced || (vtrig && !veto);
	end

endmodule

### tb/sv/hpt_decision_checker.sv
`timescale 1ns / 100ps

module hpt_decision_checker import hpt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [15:0]          s_tdata,
	input  logic [FUNC_W-1:0]    s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [7:0]           m_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   mismatches,
	output int                   pending
);

	localparam int N_DET = DEF_NUM_DETECTORS;
	localparam int N_PAT = DEF_NUM_PATTERNS;
	localparam logic [DEF_COUNT_WIDTH-1:0] COUNT_TOP = '1;

	// m_tdata layout, msb first
	typedef struct packed {
		logic [2:0] pad;
		logic       saturated;
		logic       forced;
		logic       vetoed;
		logic       triggered;
		logic       accepted;
	} decision_bits_t;

	logic [DEF_COUNT_WIDTH-1:0] hits     [N_DET];
	logic [REQ_W-1:0]           need_cnt [N_PAT][N_DET];
	logic                       need_min [N_PAT][N_DET];
	logic [MODE_W-1:0]          row_kind [N_PAT];
	logic [CFG_W-1:0]           det_use;
	logic [CFG_W-1:0]           pat_use;
	logic                       veto_off;

	decision_bits_t decision_q [$];
	decision_bits_t want;
	decision_bits_t got;
	item_t          taken;

	function automatic int det_span();
		return (det_use > N_DET) ? N_DET : int'(det_use);
	endfunction

	function automatic int pat_span();
		return (pat_use > N_PAT) ? N_PAT : int'(pat_use);
	endfunction

	function automatic logic row_hit(int p);
		for (int d = 0; d < det_span(); d++) begin
			if (need_min[p][d]) begin
				if (hits[d] < need_cnt[p][d])
					return 1'b0;
			end else if (hits[d] != need_cnt[p][d]) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	function automatic logic any_row(logic [MODE_W-1:0] kind);
		for (int p = 0; p < pat_span(); p++)
			if (row_kind[p] == kind && row_hit(p))
				return 1'b1;
		return 1'b0;
	endfunction

	// Update the hit counters / pattern table, then form the decision.
	function automatic decision_bits_t apply_item(item_t it);
		decision_bits_t r;
		logic forced;
		logic vtrig;
		logic veto;
		r = '0;
		case (it.func)
			FUNC_CLEAR: begin
				for (int d = 0; d < N_DET; d++)
					hits[d] = '0;
			end
			FUNC_HIT: begin
				if (int'(it.detector) < det_span()) begin
					if (hits[it.detector] != COUNT_TOP)
						hits[it.detector] = hits[it.detector] + DEF_COUNT_WIDTH'(1);
					r.accepted = 1'b1;
				end
			end
			FUNC_WRITE: begin
				need_cnt[it.pattern][it.detector] = it.required_count;
				need_min[it.pattern][it.detector] = it.more_allowed;
				row_kind[it.pattern] = it.mode;
			end
			default: begin
			end
		endcase
		forced = any_row(MODE_FORCED);
		vtrig  = any_row(MODE_VETOABLE);
		veto   = !veto_off && any_row(MODE_VETO);
		r.forced    = forced;
		r.vetoed    = veto && !forced;
		r.triggered = forced || (vtrig && !veto);
		for (int d = 0; d < N_DET; d++)
			if (hits[d] == COUNT_TOP)
				r.saturated = 1'b1;
		return r;
	endfunction

	task automatic note_field(string name, logic [2:0] exp_v, logic [2:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s expected %0h, got %0h", $realtime, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < N_DET; d++)
				hits[d] = '0;
			for (int p = 0; p < N_PAT; p++) begin
				row_kind[p] = MODE_VETOABLE;
				for (int d = 0; d < N_DET; d++) begin
					need_cnt[p][d] = '0;
					need_min[p][d] = 1'b0;
				end
			end
			det_use  = CFG_W'(N_DET);
			pat_use  = '0;
			veto_off = 1'b0;
			decision_q.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = decision_bits_t'(m_tdata);
				if (decision_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result %02h with no item pending", $realtime, m_tdata);
				end else begin
					want = decision_q.pop_front();
					note_field("accepted",       3'(want.accepted),  3'(got.accepted));
					note_field("triggered",      3'(want.triggered), 3'(got.triggered));
					note_field("vetoed",         3'(want.vetoed),    3'(got.vetoed));
					note_field("forced_trigger", 3'(want.forced),    3'(got.forced));
					note_field("saturated",      3'(want.saturated), 3'(got.saturated));
					note_field("padding",        want.pad,           got.pad);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_DETECTORS: det_use  = cfg_data;
					CFG_PATTERNS:  pat_use  = cfg_data;
					CFG_IGNORE:    veto_off = cfg_data[0];
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready) begin
				taken.func           = func_t'(s_tuser);
				taken.detector       = s_tdata[2:0];
				taken.pattern        = s_tdata[5:3];
				taken.mode           = s_tdata[7:6];
				taken.required_count = s_tdata[11:8];
				taken.more_allowed   = s_tdata[12];
				decision_q.insert(decision_q.size(), apply_item(taken));
			end
			pending <= decision_q.size();
		end
	end

endmodule

### tb/sv/tb_hit_pattern_trigger_veto.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the hit-pattern trigger/veto block.
// Prediction and comparison live in hpt_decision_checker.
module tb_hit_pattern_trigger_veto;
	import hpt_pkg::*;

	// Codes with no name in the package
	localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [15:0]          s_tdata   = '0;   // detector[2:0] pattern[5:3] mode[7:6]
	                                        // required_count[11:8] more_allowed[12]
	logic [FUNC_W-1:0]    s_tuser   = FUNC_NOP; // func[1:0]
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [7:0]           m_tdata;          // accepted[0] triggered[1] vetoed[2]
	                                        // forced_trigger[3] saturated[4]
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_DETECTORS;
	logic [CFG_W-1:0]     cfg_data  = '0;

	int mismatches;
	int pending;

	// Random idling on both sides; switched off for the tail of the run
	bit gaps_on = 1'b1;
	// Current detectors_in_use, so that most hits land on live channels
	int det_now = DEF_NUM_DETECTORS;

	always #2 clk = ~clk;

	hit_pattern_trigger_veto i_dut (.*);

	hpt_decision_checker i_checker (.*);

	// Hard stop in case the handshake hangs
	initial begin
		#4_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Receiver: ready most of the time, with occasional stall bursts.
	initial begin
		@(posedge clk);
		forever begin
			if (gaps_on && $urandom_range(0, 9) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// One item on the slave channel. An optional gap comes first; valid is
	// left high on return so back-to-back items need no re-assertion.
	// Ready is sampled mid-cycle, where it holds the value seen at the next edge.
	task automatic push_item(func_t f, logic [DET_W-1:0] det, logic [PAT_W-1:0] pat,
			logic [MODE_W-1:0] md, logic [REQ_W-1:0] req, logic more);
		bit took;
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= {3'b000, more, req, md, pat, det};
		do begin
			@(negedge clk);
			took = s_tready;
			@(posedge clk);
		end while (!took);
	endtask

	// Fields a hit/clear/nop does not use still get random content.
	task automatic send_op(func_t f, logic [DET_W-1:0] det);
		push_item(f, det, PAT_W'($urandom), MODE_W'($urandom), REQ_W'($urandom),
			1'($urandom));
	endtask

	task automatic hit(logic [DET_W-1:0] det);
		send_op(FUNC_HIT, det);
	endtask

	task automatic write_cell(logic [PAT_W-1:0] pat, logic [DET_W-1:0] det,
			logic [MODE_W-1:0] md, logic [REQ_W-1:0] req, logic more);
		push_item(FUNC_WRITE, det, pat, md, req, more);
	endtask

	// Small counts so that rows actually match; the odd full-range count
	// and the unused mode code show up now and then.
	task automatic random_cell(logic [PAT_W-1:0] pat, logic [DET_W-1:0] det);
		logic [MODE_W-1:0] md;
		logic [REQ_W-1:0]  req;
		md  = ($urandom_range(0, 9) == 0) ? MODE_UNUSED : MODE_W'($urandom_range(0, 2));
		req = ($urandom_range(0, 7) == 0) ? REQ_W'($urandom) : REQ_W'($urandom_range(0, 3));
		write_cell(pat, det, md, req, $urandom_range(0, 3) != 0);
	endtask

	// Stop sending and wait until every decision has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Write all three registers on consecutive cycles, block idle.
	task automatic set_regs(logic [CFG_W-1:0] det, logic [CFG_W-1:0] pat, logic ign);
		logic [CFG_W-2:0] junk;
		junk = (CFG_W-1)'($urandom);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DETECTORS;
		cfg_data  <= det;
		@(posedge clk);
		cfg_index <= CFG_PATTERNS;
		cfg_data  <= pat;
		@(posedge clk);
		cfg_index <= CFG_IGNORE;
		cfg_data  <= {junk, ign};
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		det_now = int'(det);
	endtask

	// Mostly events: a clear followed by a handful of hits. Mixed in are
	// pattern rewrites, saturating bursts and fully random noise items.
	task automatic run_phase(int budget);
		int sent;
		int pick;
		int burst;
		int span;
		logic [DET_W-1:0] det;
		sent = 0;
		span = (det_now == 0) ? 1 : ((det_now > DEF_NUM_DETECTORS) ? DEF_NUM_DETECTORS : det_now);
		while (sent < budget) begin
			pick = $urandom_range(0, 19);
			if (pick < 13) begin
				send_op(FUNC_CLEAR, DET_W'($urandom));
				burst = $urandom_range(0, 12);
				repeat (burst) begin
					if ($urandom_range(0, 9) == 0)
						hit(DET_W'($urandom));
					else
						hit(DET_W'($urandom_range(0, span - 1)));
				end
				sent += burst + 1;
			end else if (pick < 16) begin
				random_cell(PAT_W'($urandom), DET_W'($urandom));
				sent++;
			end else if (pick == 16) begin
				det = DET_W'($urandom_range(0, span - 1));
				burst = $urandom_range(14, 18);
				repeat (burst)
					hit(det);
				sent += burst;
			end else begin
				push_item(func_t'(FUNC_W'($urandom)), DET_W'($urandom), PAT_W'($urandom),
					MODE_W'($urandom), REQ_W'($urandom), 1'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		logic [CFG_W-1:0] det_pick;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load every cell of the table while no row is evaluated (reset
		// patterns_in_use is 0), so no later compare sees an unwritten cell.
		for (int p = 0; p < DEF_NUM_PATTERNS; p++)
			for (int d = 0; d < DEF_NUM_DETECTORS; d++)
				random_cell(PAT_W'(p), DET_W'(d));

		// Two live detectors, rows 0..2:
		//   row 0 vetoable: d0 == 1
		//   row 1 veto:     d1 == 1
		//   row 2 forced:   d1 >= 2
		set_regs(4'd2, 4'd3, 1'b0);
		write_cell(3'd0, 3'd0, MODE_VETOABLE, 4'd1, 1'b0);
		write_cell(3'd0, 3'd1, MODE_VETOABLE, 4'd0, 1'b1);
		write_cell(3'd1, 3'd0, MODE_VETO,     4'd0, 1'b1);
		write_cell(3'd1, 3'd1, MODE_VETO,     4'd1, 1'b0);
		write_cell(3'd2, 3'd0, MODE_FORCED,   4'd0, 1'b1);
		write_cell(3'd2, 3'd1, MODE_FORCED,   4'd2, 1'b1);
		send_op(FUNC_CLEAR, 3'd0);
		hit(3'd0);                  // vetoable row alone -> trigger
		hit(3'd1);                  // veto row joins -> vetoed
		hit(3'd1);                  // d1 == 2: veto row drops out, forced row fires
		send_op(FUNC_NOP, 3'd0);
		hit(3'd5);                  // channel not in use -> not accepted
		write_cell(3'd7, 3'd7, MODE_UNUSED, 4'd15, 1'b1);  // unused mode, top count
		repeat (15) hit(3'd0);      // run d0 into saturation, then hold it

		// Same event with vetoes ignored
		set_regs(4'd2, 4'd3, 1'b1);
		send_op(FUNC_CLEAR, 3'd0);
		hit(3'd0);
		hit(3'd1);

		// No detectors in use: every evaluated row matches
		set_regs(4'd0, 4'd3, 1'b0);
		send_op(FUNC_NOP, 3'd0);

		// Oversized register values clamp to the table size
		set_regs(4'd15, 4'd15, 1'b0);
		send_op(FUNC_NOP, 3'd0);
		send_op(FUNC_CLEAR, 3'd0);
		hit(3'd7);

		// Write to the spare register index; nothing should change
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SPARE;
		cfg_data  <= CFG_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		send_op(FUNC_NOP, 3'd0);

		// Random phases; first few pin the register extremes
		for (int ph = 0; ph < 16; ph++) begin
			if (ph >= 13)
				gaps_on = 1'b0;
			det_pick = ($urandom_range(0, 4) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(1, 8));
			case (ph)
				0: set_regs(4'd8, 4'd8, 1'b0);
				1: set_regs(4'd1, 4'd8, 1'b1);
				2: set_regs(4'd8, 4'd0, 1'b0);
				3: set_regs(4'd3, 4'd8, 1'b0);
				default: set_regs(det_pick, CFG_W'($urandom), 1'($urandom));
			endcase
			run_phase(90);
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
